// ===== rtl/mpq_pkg.sv =====
// mpq_pkg: shared types and constants for the min priority queue.
// Used by mpq_cell and min_priority_queue_core. No dependencies.

package mpq_pkg;

    // fixed port widths
    localparam int OP_W     = 2;
    localparam int KEY_IO_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic shift_in;   // insert: cells above the new key move one place up
        logic shift_out;  // pop: every cell takes its right neighbor's key
    } cell_cmd_t;

endpackage

// ===== rtl/min_priority_queue_core.sv =====
// min_priority_queue_core: bounded min priority queue kept as a sorted chain of cells.
// A result is registered and is valid in the cycle after its input beat is accepted.
// Throughput: one item per cycle while the output is drained; every cell compares against the new key in parallel.
// A new beat is taken while the output register is empty or being drained.
// Reset clears the entry count and the output valid flag; keys and result data are not cleared.
// Depends on mpq_pkg and mpq_cell.

module min_priority_queue_core #(
    parameter int CAPACITY = 32,
    parameter int KEY_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mpq_pkg::OP_W-1:0]            operation,
    input  logic signed [mpq_pkg::KEY_IO_W-1:0] key_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mpq_pkg::KEY_IO_W-1:0] key_out,
    output logic                                found,
    output logic [mpq_pkg::STATUS_W-1:0]        status,
    output logic [mpq_pkg::OCC_W-1:0]           occupancy
);

    localparam int KW     = (KEY_BITS > mpq_pkg::KEY_IO_W) ? mpq_pkg::KEY_IO_W : KEY_BITS;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = CNT_W + mpq_pkg::OCC_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg;
    logic signed [mpq_pkg::KEY_IO_W-1:0] key_out_reg, key_out_next;
    logic               found_reg, found_next;
    logic [mpq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [mpq_pkg::OCC_W-1:0]    occ_reg;
    logic [WIDE_W-1:0]  count_wide;

    logic               accept;
    logic               is_full;
    logic               is_empty;
    mpq_pkg::cell_cmd_t cmd;
    logic signed [KW-1:0] key_load;

    logic signed [KW-1:0] cell_key [CAPACITY];
    logic                 cell_keeps [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);
    assign key_load = key_in[KW-1:0];

    // chain of cells, slot 0 holds the smallest key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic signed [KW-1:0] left_key;
        logic                 left_keeps;
        logic signed [KW-1:0] right_key;

        if (i == 0)
        begin : g_head
            assign left_key   = key_load;
            assign left_keeps = 1'b1;
        end
        else
        begin : g_body
            assign left_key   = cell_key[i-1];
            assign left_keeps = cell_keeps[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key = cell_key[i];
        end
        else
        begin : g_mid
            assign right_key = cell_key[i+1];
        end

        mpq_cell #(
            .KEY_W (KW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (IDX < count_reg),
            .new_key    (key_load),
            .left_key   (left_key),
            .left_keeps (left_keeps),
            .right_key  (right_key),
            .key        (cell_key[i]),
            .keeps      (cell_keeps[i])
        );
    end

    // operation decode and result
    always_comb
    begin
        cmd          = '0;
        count_next   = count_reg;
        key_out_next = '0;
        found_next   = 1'b0;
        status_next  = mpq_pkg::ST_OK;
        unique case (operation)
            mpq_pkg::OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = mpq_pkg::ST_FULL;
                end
                else
                begin
                    cmd.shift_in = accept;
                    count_next   = count_reg + 1'b1;
                end
            end
            mpq_pkg::OP_POP, mpq_pkg::OP_PEEK:
            begin
                if (is_empty)
                begin
                    status_next = mpq_pkg::ST_EMPTY;
                end
                else
                begin
                    key_out_next = mpq_pkg::KEY_IO_W'(cell_key[0]);
                    found_next   = 1'b1;
                    if (operation == mpq_pkg::OP_POP)
                    begin
                        cmd.shift_out = accept;
                        count_next    = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                // unused code: no change, plain ok result
            end
        endcase
    end

    assign count_wide = WIDE_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_out_reg <= key_out_next;
            found_reg   <= found_next;
            status_reg  <= status_next;
            occ_reg     <= count_wide[mpq_pkg::OCC_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == mpq_pkg::OP_INSERT && !is_full)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not add an entry");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> status == mpq_pkg::ST_OK)
        else $error("found beat with non-ok status");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
        else $error("head of chain out of order");

endmodule

// ===== rtl/mpq_cell.sv =====
// mpq_cell: one slot of the sorted key chain.
// Depends on mpq_pkg (cell_cmd_t).

module mpq_cell #(
    parameter int KEY_W = 32
) (
    input  logic                    clk,
    input  mpq_pkg::cell_cmd_t      cmd,
    input  logic                    occupied,
    input  logic signed [KEY_W-1:0] new_key,
    input  logic signed [KEY_W-1:0] left_key,
    input  logic                    left_keeps,
    input  logic signed [KEY_W-1:0] right_key,
    output logic signed [KEY_W-1:0] key,
    output logic                    keeps
);

    logic signed [KEY_W-1:0] key_reg;

    // a slot keeps its key on insert when it holds one no larger than the new key
    assign keeps = occupied && (key_reg <= new_key);
    assign key   = key_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_in)
        begin
            if (!keeps)
            begin
                // the first slot that does not keep takes the new key
                key_reg <= left_keeps ? new_key : left_key;
            end
        end
        else if (cmd.shift_out)
        begin
            key_reg <= right_key;
        end
    end

endmodule
